@@ rtl/calculator_microprogram_core_step_assert.svh @@
// ---------------------------------------------------------------------------
// calculator_microprogram_core_step_assert.svh
// Assertion macros used by the calculator core top level.
// ---------------------------------------------------------------------------
`ifndef CALCULATOR_MICROPROGRAM_CORE_STEP_ASSERT_SVH
`define CALCULATOR_MICROPROGRAM_CORE_STEP_ASSERT_SVH

// Condition must never hold while out of reset
`define CMCS_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Antecedent in this cycle requires consequent in the same cycle
`define CMCS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent in this cycle requires consequent in the next cycle
`define CMCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/cmcs_pkg.sv @@
// ---------------------------------------------------------------------------
// cmcs_pkg
// Types, codes and constant tables of the calculator microprogram core.
// ---------------------------------------------------------------------------
package cmcs_pkg;

    localparam int REG_DIGITS = 42;
    localparam int DOT_DIGITS = 14;

    localparam logic [31:0] KEYPAD_MASK  = 32'h00fc0000;
    localparam logic [7:0]  PIDX_LIMIT   = 8'h1f;
    localparam logic [7:0]  PIDX_JUMP    = 8'h5f;
    localparam logic [5:0]  MADDR_BRANCH = 6'd59;
    localparam logic [6:0]  MADDR_BASE   = 7'd60;
    localparam logic [5:0]  CYC_SEG1     = 6'd27;
    localparam logic [5:0]  CYC_SEG2     = 6'd36;
    localparam logic [5:0]  CYC_LAST     = 6'd41;
    localparam logic [3:0]  DOT_LIMIT    = 4'd12;

    // Program ROM phase for each digit time
    localparam logic [3:0] PHASE_MAP [REG_DIGITS] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd3, 4'd4, 4'd5,
        4'd3, 4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd3, 4'd4, 4'd5, 4'd3, 4'd4, 4'd5,
        4'd6, 4'd7, 4'd8, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8,
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5
    };

    typedef enum logic [1:0] {
        FUNC_STEP  = 2'd0,
        FUNC_MICRO = 2'd1,
        FUNC_CMD   = 2'd2,
        FUNC_PROG  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMD,
        ST_PROG,
        ST_MICRO,
        ST_EXEC
    } seq_state_t;

    typedef enum logic [2:0] {
        MAIN_KEEP, MAIN_NEXT3, MAIN_SUM, MAIN_S,
        MAIN_OR_ALL, MAIN_S_SUM, MAIN_OR_S, MAIN_OR_SUM
    } main_sel_t;

    typedef enum logic [1:0] {
        S_KEEP, S_FROM_S1, S_SUM, S_S1_SUM
    } s_sel_t;

    typedef enum logic [1:0] {
        S1_KEEP, S1_SUM, S1_KEY, S1_OR_SUM
    } s1_sel_t;

    typedef enum logic [1:0] {
        STK_KEEP, STK_PUSH, STK_ROT, STK_OR
    } stk_sel_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] rom_addr;
        logic [31:0] rom_data;
        logic [3:0]  serial_in;
        logic [3:0]  key_column;
        logic [3:0]  key_row;
    } req_item_t;

    typedef struct packed {
        logic [3:0] serial_out;
        logic [3:0] digit_index;
        logic       digit_dot;
        logic [3:0] dot_position;
        logic       display_on;
        logic       key_event;
        logic       carry_out;
    } rsp_item_t;

    // Execute command from the sequencer to the core
    typedef struct packed {
        logic        exec;
        logic [31:0] cmd;
        logic [27:0] op;
        logic [3:0]  serial_in;
        logic [3:0]  key_column;
        logic [3:0]  key_row;
    } core_ctl_t;

    // Core state seen by the ROM fetch
    typedef struct packed {
        logic [5:0] cycle;
        logic       carry;
        logic [7:0] cmd_ptr0;
    } core_stat_t;

endpackage

@@ rtl/calculator_microprogram_core_step.sv @@
// Step transaction: command ROM read, program ROM read, micro ROM read, then
// execute, in states ST_CMD, ST_PROG, ST_MICRO and ST_EXEC; the result is
// registered in execute, which holds while the previous result is not taken;
// the next item is taken in the execute cycle. ROM loads return no result.
// Reset (rst_n low, async): digit registers and all core state cleared; ROM
// contents are undefined until loaded.
// ---------------------------------------------------------------------------
// calculator_microprogram_core_step
// Top level: transaction handshake, ROM fetch sequencer and result register.
// ---------------------------------------------------------------------------
`include "calculator_microprogram_core_step_assert.svh"

module calculator_microprogram_core_step
    import cmcs_pkg::*;
#(
    parameter int MICRO_DEPTH   = 68,
    parameter int COMMAND_DEPTH = 256,
    parameter int PROGRAM_DEPTH = 2304
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    localparam int MAW = $clog2(MICRO_DEPTH);
    localparam int CAW = $clog2(COMMAND_DEPTH);
    localparam int PAW = $clog2(PROGRAM_DEPTH);

    seq_state_t state_reg, state_next;
    req_item_t  item_reg;
    logic [7:0] cp_reg, cp_next;
    rsp_item_t  rsp_reg;
    logic       rsp_valid_reg;

    core_ctl_t  ctl;
    core_stat_t stat;
    rsp_item_t  core_rsp;

    logic        req_fire, step_fire, out_free;
    logic        micro_we, cmd_we, prog_we;
    logic        cmd_re, prog_re, micro_re;
    logic [31:0] cmd_rdata;
    logic [7:0]  prog_rdata;
    logic [27:0] micro_rdata;
    logic [7:0]  pidx;
    logic [11:0] paddr;
    logic [5:0]  mraw;
    logic [6:0]  maddr;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;
    assign step_fire = req_fire && func_t'(req.func) == FUNC_STEP;

    // ROM loads, out-of-range addresses dropped
    assign micro_we = req_fire && func_t'(req.func) == FUNC_MICRO
                      && {20'd0, req.rom_addr} < MICRO_DEPTH;
    assign cmd_we   = req_fire && func_t'(req.func) == FUNC_CMD
                      && {20'd0, req.rom_addr} < COMMAND_DEPTH;
    assign prog_we  = req_fire && func_t'(req.func) == FUNC_PROG
                      && {20'd0, req.rom_addr} < PROGRAM_DEPTH;

    // Program index by segment, jump words redirect to the jump routine
    always_comb
    begin
        if (stat.cycle < CYC_SEG1)
        begin
            pidx = cmd_rdata[7:0];
        end
        else if (stat.cycle < CYC_SEG2)
        begin
            pidx = cmd_rdata[15:8];
        end
        else if (cmd_rdata[23:16] > PIDX_LIMIT)
        begin
            pidx = PIDX_JUMP;
        end
        else
        begin
            pidx = cmd_rdata[23:16];
        end
    end

    assign paddr = {4'd0, pidx} * 12'd9 + {8'd0, PHASE_MAP[stat.cycle]};

    // Micro address, upper codes branch on carry
    assign mraw  = prog_rdata[5:0];
    assign maddr = (mraw > MADDR_BRANCH)
                   ? ((({1'b0, mraw} - MADDR_BASE) << 1) + MADDR_BASE
                      + {6'd0, !stat.carry})
                   : {1'b0, mraw};

    assign cp_next = (stat.cycle == 6'd0) ? stat.cmd_ptr0 : cp_reg;

    // Sequencer next state
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  state_next = step_fire ? ST_CMD : ST_IDLE;
            ST_CMD:   state_next = ST_PROG;
            ST_PROG:  state_next = ST_MICRO;
            ST_MICRO: state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (!out_free)
                begin
                    state_next = ST_EXEC;
                end
                else if (step_fire)
                begin
                    state_next = ST_CMD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        req_ready = 1'b0;
        cmd_re    = 1'b0;
        prog_re   = 1'b0;
        micro_re  = 1'b0;
        ctl.exec  = 1'b0;
        case (state_reg)
            ST_IDLE:  req_ready = 1'b1;
            ST_CMD:   cmd_re = 1'b1;
            ST_PROG:  prog_re = 1'b1;
            ST_MICRO: micro_re = 1'b1;
            ST_EXEC:
            begin
                ctl.exec  = out_free;
                req_ready = out_free;
            end
            default:  req_ready = 1'b0;
        endcase
    end

    assign ctl.cmd        = cmd_rdata;
    assign ctl.op         = micro_rdata;
    assign ctl.serial_in  = item_reg.serial_in;
    assign ctl.key_column = item_reg.key_column;
    assign ctl.key_row    = item_reg.key_row;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cp_reg        <= 8'd0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_re)
            begin
                cp_reg <= cp_next;
            end
            if (ctl.exec)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (step_fire)
        begin
            item_reg <= req;
        end
        if (ctl.exec)
        begin
            rsp_reg <= core_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    cmcs_ram #(.WIDTH(32), .DEPTH(COMMAND_DEPTH)) u_cmd_rom (
        .clk   (clk),
        .we    (cmd_we),
        .waddr (req.rom_addr[CAW-1:0]),
        .wdata (req.rom_data),
        .re    (cmd_re),
        .raddr (cp_next[CAW-1:0]),
        .rdata (cmd_rdata)
    );

    cmcs_ram #(.WIDTH(8), .DEPTH(PROGRAM_DEPTH)) u_prog_rom (
        .clk   (clk),
        .we    (prog_we),
        .waddr (req.rom_addr[PAW-1:0]),
        .wdata (req.rom_data[7:0]),
        .re    (prog_re),
        .raddr (paddr[PAW-1:0]),
        .rdata (prog_rdata)
    );

    cmcs_ram #(.WIDTH(28), .DEPTH(MICRO_DEPTH)) u_micro_rom (
        .clk   (clk),
        .we    (micro_we),
        .waddr (req.rom_addr[MAW-1:0]),
        .wdata (req.rom_data[27:0]),
        .re    (micro_re),
        .raddr (maddr[MAW-1:0]),
        .rdata (micro_rdata)
    );

    cmcs_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .stat   (stat),
        .result (core_rsp)
    );

    // Checks
    `CMCS_ASSERT_NEVER(a_cycle_range, stat.cycle > CYC_LAST, "cycle counter out of range")
    `CMCS_ASSERT_NEXT(a_step_fetch, step_fire, state_reg == ST_CMD, "step did not start fetch")
    `CMCS_ASSERT_NEXT(a_exec_result, ctl.exec, rsp_valid_reg, "execute gave no result")
    `CMCS_ASSERT_SAME(a_micro_addr, micro_re, {25'd0, maddr} < MICRO_DEPTH, "micro address out of range")

endmodule

@@ rtl/cmcs_ram.sv @@
// ---------------------------------------------------------------------------
// cmcs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cmcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/cmcs_core.sv @@
// ---------------------------------------------------------------------------
// cmcs_core
// Circulating digit registers, S/S1/carry/keypad state and the execute step.
// Registers rotate one digit per step so every access sits at a fixed tap.
// ---------------------------------------------------------------------------
module cmcs_core
    import cmcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  core_ctl_t  ctl,
    output core_stat_t stat,
    output rsp_item_t  result
);

    // Tap k of each register holds digit (cycle + k) mod REG_DIGITS
    logic [3:0] main_reg  [REG_DIGITS];
    logic [3:0] shift_reg [REG_DIGITS];
    logic [3:0] stack_reg [REG_DIGITS];
    logic [3:0] main_next  [REG_DIGITS];
    logic [3:0] shift_next [REG_DIGITS];
    logic [3:0] stack_next [REG_DIGITS];
    logic       dots_reg  [DOT_DIGITS];
    logic       dots_next [DOT_DIGITS];

    logic [3:0] acc_s_reg, acc_s_next;
    logic [3:0] acc_s1_reg, acc_s1_next;
    logic       carry_reg, carry_next;
    logic       kf_reg, kf_next;
    logic [5:0] cycle_reg, cycle_next;
    logic [3:0] dpos_reg, dpos_next;
    logic       disp_reg, disp_next;

    logic [11:0] d_prod;
    logic [3:0]  d;
    logic        key_here;
    logic        keypad_cmd;
    logic [7:0]  pidx_hi;
    logic [3:0]  alpha, beta, gamma, sigma, sout;
    logic [4:0]  sum;
    logic [3:0]  x, y, z;

    // Digit position = cycle / 3 by reciprocal multiply (exact below 42)
    assign d_prod   = {6'd0, cycle_reg} * 12'd43;
    assign d        = d_prod[10:7];
    assign key_here = (ctl.key_column != 4'd0) && (d == ctl.key_column - 4'd1);

    assign stat.cycle    = cycle_reg;
    assign stat.carry    = carry_reg;
    assign stat.cmd_ptr0 = {main_reg[39], main_reg[36]};

    assign keypad_cmd = (ctl.cmd & KEYPAD_MASK) != 32'd0;
    assign pidx_hi    = ctl.cmd[23:16];
    assign x          = stack_reg[0];
    assign y          = stack_reg[1];
    assign z          = stack_reg[2];

    // Execute one microinstruction in model order
    always_comb
    begin
        main_next   = main_reg;
        shift_next  = shift_reg;
        stack_next  = stack_reg;
        dots_next   = dots_reg;
        acc_s_next  = acc_s_reg;
        acc_s1_next = acc_s1_reg;
        carry_next  = carry_reg;
        kf_next     = kf_reg;
        dpos_next   = dpos_reg;
        disp_next   = disp_reg;
        alpha       = 4'd0;
        beta        = 4'd0;
        gamma       = 4'd0;

        if (cycle_reg == 6'd0 && !keypad_cmd)
        begin
            kf_next = 1'b0;
        end
        // Jump target digits into M37/M40
        if (cycle_reg == CYC_SEG2 && pidx_hi > PIDX_LIMIT)
        begin
            main_next[1] = pidx_hi[3:0];
            main_next[4] = pidx_hi[7:4];
        end

        if (ctl.op[25] && !key_here && ctl.key_row != 4'd0)
        begin
            acc_s1_next = acc_s1_next | ctl.key_row;
        end

        // Adder operands
        if (ctl.op[0])  alpha = alpha | main_reg[0];
        if (ctl.op[1])  alpha = alpha | shift_reg[0];
        if (ctl.op[2])  alpha = alpha | stack_reg[0];
        if (ctl.op[3])  alpha = alpha | ~main_reg[0];
        if (ctl.op[4] && !carry_reg) alpha = alpha | 4'ha;
        if (ctl.op[5])  alpha = alpha | acc_s_reg;
        if (ctl.op[6])  alpha = alpha | 4'd4;
        if (ctl.op[7])  beta = beta | acc_s_reg;
        if (ctl.op[8])  beta = beta | ~acc_s_reg;
        if (ctl.op[9])  beta = beta | acc_s1_next;
        if (ctl.op[10]) beta = beta | 4'd6;
        if (ctl.op[11]) beta = beta | 4'd1;

        // Keypad poll or display/dot bookkeeping
        if (keypad_cmd)
        begin
            if (ctl.key_row == 4'd0)
            begin
                kf_next = 1'b0;
            end
        end
        else
        begin
            disp_next = 1'b1;
            if (key_here && ctl.key_row != 4'd0)
            begin
                acc_s1_next = ctl.key_row;
                kf_next     = 1'b1;
            end
            if (carry_reg && d < DOT_LIMIT)
            begin
                dpos_next = d;
            end
            dots_next[d] = carry_reg;
        end

        if (ctl.op[12]) gamma[0] = gamma[0] | carry_reg;
        if (ctl.op[13]) gamma[0] = gamma[0] | ~carry_reg;
        if (ctl.op[14]) gamma[0] = gamma[0] | ~kf_next;

        sum   = {1'b0, alpha} + {1'b0, beta} + {1'b0, gamma};
        sigma = sum[3:0];
        if (ctl.op[21])
        begin
            carry_next = sum[4];
        end

        // Main register write
        if (ctl.cmd[31:24] == 8'd0 || cycle_reg >= CYC_SEG2)
        begin
            case (main_sel_t'(ctl.op[17:15]))
                MAIN_NEXT3:  main_next[0] = main_reg[3];
                MAIN_SUM:    main_next[0] = sigma;
                MAIN_S:      main_next[0] = acc_s_reg;
                MAIN_OR_ALL: main_next[0] = main_reg[0] | acc_s_reg | sigma;
                MAIN_S_SUM:  main_next[0] = acc_s_reg | sigma;
                MAIN_OR_S:   main_next[0] = main_reg[0] | acc_s_reg;
                MAIN_OR_SUM: main_next[0] = main_reg[0] | sigma;
                default:     main_next[0] = main_reg[0];
            endcase
            if (ctl.op[18]) main_next[REG_DIGITS-1] = sigma;
            if (ctl.op[19]) main_next[REG_DIGITS-2] = sigma;
        end

        // Serial register: optional S write, then digit out and in
        if (ctl.op[20])
        begin
            shift_next[0] = acc_s_reg;
        end
        sout          = shift_next[0];
        shift_next[0] = ctl.serial_in;

        case (s_sel_t'(ctl.op[23:22]))
            S_FROM_S1: acc_s_next = acc_s1_next;
            S_SUM:     acc_s_next = sigma;
            S_S1_SUM:  acc_s_next = acc_s1_next | sigma;
            default:   acc_s_next = acc_s_reg;
        endcase
        // S1_KEY leaves S1 as it is
        case (s1_sel_t'(ctl.op[25:24]))
            S1_SUM:    acc_s1_next = sigma;
            S1_OR_SUM: acc_s1_next = acc_s1_next | sigma;
            default:   acc_s1_next = acc_s1_next;
        endcase

        // Stack register
        case (stk_sel_t'(ctl.op[27:26]))
            STK_PUSH:
            begin
                stack_next[2] = y;
                stack_next[1] = x;
                stack_next[0] = sigma;
            end
            STK_ROT:
            begin
                stack_next[0] = y;
                stack_next[1] = z;
                stack_next[2] = x;
            end
            STK_OR:
            begin
                stack_next[0] = sigma | y;
                stack_next[1] = x | z;
                stack_next[2] = y | x;
            end
            default:
            begin
                stack_next[0] = x;
            end
        endcase

        cycle_next = (cycle_reg == CYC_LAST) ? 6'd0 : cycle_reg + 6'd1;

        result.serial_out   = sout;
        result.digit_index  = d;
        result.digit_dot    = dots_next[d];
        result.dot_position = dpos_next;
        result.display_on   = disp_next;
        result.key_event    = kf_next;
        result.carry_out    = carry_next;
    end

    // State update, registers rotate by one digit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < REG_DIGITS; k++)
            begin
                main_reg[k]  <= 4'd0;
                shift_reg[k] <= 4'd0;
                stack_reg[k] <= 4'd0;
            end
            for (int k = 0; k < DOT_DIGITS; k++)
            begin
                dots_reg[k] <= 1'b0;
            end
            acc_s_reg  <= 4'd0;
            acc_s1_reg <= 4'd0;
            carry_reg  <= 1'b0;
            kf_reg     <= 1'b0;
            cycle_reg  <= 6'd0;
            dpos_reg   <= 4'd0;
            disp_reg   <= 1'b0;
        end
        else if (ctl.exec)
        begin
            for (int k = 0; k < REG_DIGITS; k++)
            begin
                main_reg[k]  <= main_next[(k == REG_DIGITS-1) ? 0 : k + 1];
                shift_reg[k] <= shift_next[(k == REG_DIGITS-1) ? 0 : k + 1];
                stack_reg[k] <= stack_next[(k == REG_DIGITS-1) ? 0 : k + 1];
            end
            dots_reg   <= dots_next;
            acc_s_reg  <= acc_s_next;
            acc_s1_reg <= acc_s1_next;
            carry_reg  <= carry_next;
            kf_reg     <= kf_next;
            cycle_reg  <= cycle_next;
            dpos_reg   <= dpos_next;
            disp_reg   <= disp_next;
        end
    end

endmodule
